// ----- rtl/sm64ke_pkg.sv -----
// Shared types and constants for the splitmix64 key and uniform engine.
// Used by every module in rtl/; depends on nothing else.
package sm64ke_pkg;

    localparam logic [63:0] GOLD = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX2 = 64'h94D049BB133111EB;

    localparam int SHIFT_A = 30;
    localparam int SHIFT_B = 27;
    localparam int SHIFT_C = 31;

    localparam int MAX_VALUES_DEF = 64;

    // Command queue between front and back.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = 1;

    // Last step index of the shared 32x32 multiplier sequence.
    localparam logic [2:0] MUL_LOW_STEPS  = 3'd3;
    localparam logic [2:0] MUL_FULL_STEPS = 3'd4;

    typedef enum logic [2:0] {
        FN_KEY      = 3'd0,
        FN_PAIR     = 3'd1,
        FN_SPLIT    = 3'd2,
        FN_FOLD_IN  = 3'd3,
        FN_UNIFORM  = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PRE,
        B_MIX0,
        B_M1,
        B_M2,
        B_SCALE,
        B_EMIT
    } t_bstate;

    typedef struct packed {
        logic        premul;    // operand is multiplied by GOLD and xored first
        logic        pre_mix;   // one hidden mix pass forms the base key
        logic        uniform;   // chained values scaled into the bounds
        logic        neg;       // bounds are reversed
        logic [5:0]  last_idx;  // index of the final result of the run
        logic [63:0] operand;
        logic [63:0] xor_word;
        logic [63:0] low;
        logic [63:0] rmag;      // magnitude of high - low
    } t_cmd;

endpackage

// ----- rtl/sm64ke_cmdq.sv -----
// Two-entry command queue that decouples the front from the back.
// Depends on sm64ke_pkg for the command type and depth.
module sm64ke_cmdq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  sm64ke_pkg::t_cmd  i_cmd,
    input  logic              i_rd,
    output logic              o_full,
    output logic              o_empty,
    output sm64ke_pkg::t_cmd  o_head
);

    sm64ke_pkg::t_cmd                r_mem [sm64ke_pkg::CMDQ_DEPTH];
    logic [sm64ke_pkg::CMDQ_AW-1:0]  r_wptr;
    logic [sm64ke_pkg::CMDQ_AW-1:0]  r_rptr;
    logic [sm64ke_pkg::CMDQ_AW:0]    r_count;
    logic                            wr_ok;
    logic                            rd_ok;

    assign o_full  = (r_count == (sm64ke_pkg::CMDQ_AW + 1)'(sm64ke_pkg::CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_ok) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_ok) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({wr_ok, rd_ok})
                2'b10:   r_count <= r_count + (sm64ke_pkg::CMDQ_AW + 1)'(1);
                2'b01:   r_count <= r_count - (sm64ke_pkg::CMDQ_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/sm64ke_front.sv -----
// Front end: accepts requests, keeps the key counter and turns each request
// into a command for the back end. Depends on sm64ke_pkg.
module sm64ke_front #(
    parameter int MAX_VALUES = sm64ke_pkg::MAX_VALUES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [2:0]          i_func,
    input  logic [63:0]         i_entropy,
    input  logic [63:0]         i_key_in,
    input  logic [63:0]         i_fold_value,
    input  logic [6:0]          i_value_count,
    input  logic signed [63:0]  i_low_bound,
    input  logic signed [63:0]  i_high_bound,
    input  logic                i_q_full,
    output logic                o_q_wr,
    output sm64ke_pkg::t_cmd    o_cmd
);

    localparam logic [6:0] MAX_CNT = 7'(MAX_VALUES);

    logic [63:0] r_key_counter;
    logic [63:0] n_key_counter;
    logic        accept;
    logic        bump;
    logic        keep;
    logic [6:0]  count_clamped;
    logic        neg;

    assign accept        = i_push && !i_q_full;
    assign n_key_counter = r_key_counter + 64'd1;
    assign count_clamped = (i_value_count > MAX_CNT) ? MAX_CNT : i_value_count;
    assign neg           = (i_high_bound < i_low_bound);

    always_comb begin
        bump             = 1'b0;
        keep             = 1'b1;
        o_cmd.premul     = 1'b0;
        o_cmd.pre_mix    = 1'b0;
        o_cmd.uniform    = 1'b0;
        o_cmd.neg        = neg;
        o_cmd.last_idx   = 6'd0;
        o_cmd.operand    = i_key_in;
        o_cmd.xor_word   = i_key_in;
        o_cmd.low        = i_low_bound;
        o_cmd.rmag       = neg ? (i_low_bound - i_high_bound) : (i_high_bound - i_low_bound);
        unique case (i_func)
            sm64ke_pkg::FN_KEY: begin
                bump           = 1'b1;
                o_cmd.premul   = 1'b1;
                o_cmd.operand  = n_key_counter;
                o_cmd.xor_word = i_entropy;
            end
            sm64ke_pkg::FN_PAIR: begin
                bump           = 1'b1;
                o_cmd.premul   = 1'b1;
                o_cmd.pre_mix  = 1'b1;
                o_cmd.operand  = n_key_counter;
                o_cmd.xor_word = i_entropy;
                o_cmd.last_idx = 6'd1;
            end
            sm64ke_pkg::FN_SPLIT: begin
                o_cmd.last_idx = 6'd1;
            end
            sm64ke_pkg::FN_FOLD_IN: begin
                o_cmd.premul   = 1'b1;
                o_cmd.operand  = i_fold_value;
            end
            sm64ke_pkg::FN_UNIFORM: begin
                // A zero count still reloads the chain, which nothing can
                // observe, so the request is simply dropped.
                keep           = (count_clamped != 7'd0);
                o_cmd.uniform  = 1'b1;
                o_cmd.last_idx = 6'(count_clamped - 7'd1);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_q_wr = accept && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_counter <= '0;
        end else if (accept && bump) begin
            r_key_counter <= n_key_counter;
        end
    end

endmodule

// ----- rtl/sm64ke_back.sv -----
// Back end: runs each command through the splitmix64 mixer and the uniform
// scaler on one shared 32x32 multiplier, and holds the result register.
// Depends on sm64ke_pkg.
module sm64ke_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  sm64ke_pkg::t_cmd  i_q_head,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [63:0]       o_word,
    output logic [5:0]        o_result_index,
    output logic              o_last
);

    sm64ke_pkg::t_bstate r_state, n_state;
    sm64ke_pkg::t_cmd    r_cmd, n_cmd;
    logic [63:0]         r_x, n_x;
    logic [63:0]         r_base, n_base;
    logic [5:0]          r_idx, n_idx;
    logic                r_pre_done, n_pre_done;
    logic [2:0]          r_step, n_step;
    logic [63:0]         r_prod, n_prod;
    logic [1:0]          r_psh, n_psh;
    logic [127:0]        r_acc, n_acc;
    logic                r_out_valid;
    logic [63:0]         r_out_word;
    logic [5:0]          r_out_idx;
    logic                r_out_last;

    logic                in_mult;
    logic [2:0]          step_last;
    logic                mul_done;
    logic [63:0]         mul_b;
    logic [31:0]         a_part;
    logic [31:0]         b_part;
    logic [127:0]        prod_shifted;
    logic [127:0]        mul_acc;
    logic [63:0]         low;
    logic [63:0]         mix0_val;
    logic [63:0]         m1_val;
    logic [63:0]         m2_val;
    logic [63:0]         unif_word;
    logic [63:0]         emit_word;
    logic                emit_last;
    logic                out_free;
    logic                emit;

    assign in_mult   = (r_state == sm64ke_pkg::B_PRE) || (r_state == sm64ke_pkg::B_M1) ||
                       (r_state == sm64ke_pkg::B_M2)  || (r_state == sm64ke_pkg::B_SCALE);
    assign step_last = (r_state == sm64ke_pkg::B_SCALE) ? sm64ke_pkg::MUL_FULL_STEPS
                                                         : sm64ke_pkg::MUL_LOW_STEPS;
    assign mul_done  = in_mult && (r_step == step_last);

    always_comb begin
        case (r_state)
            sm64ke_pkg::B_PRE: mul_b = sm64ke_pkg::GOLD;
            sm64ke_pkg::B_M1:  mul_b = sm64ke_pkg::MIX1;
            sm64ke_pkg::B_M2:  mul_b = sm64ke_pkg::MIX2;
            default:           mul_b = r_cmd.rmag;
        endcase
    end

    // Partial products in order: lo*lo, lo*hi, hi*lo, hi*hi. A product
    // taken modulo 2^64 stops after the first three.
    always_comb begin
        case (r_step[1:0])
            2'd0: begin
                a_part = r_x[31:0];
                b_part = mul_b[31:0];
                n_psh  = 2'd0;
            end
            2'd1: begin
                a_part = r_x[31:0];
                b_part = mul_b[63:32];
                n_psh  = 2'd1;
            end
            2'd2: begin
                a_part = r_x[63:32];
                b_part = mul_b[31:0];
                n_psh  = 2'd1;
            end
            default: begin
                a_part = r_x[63:32];
                b_part = mul_b[63:32];
                n_psh  = 2'd2;
            end
        endcase
    end

    assign n_prod = 64'(a_part) * 64'(b_part);

    always_comb begin
        case (r_psh)
            2'd0:    prod_shifted = {64'd0, r_prod};
            2'd1:    prod_shifted = {32'd0, r_prod, 32'd0};
            2'd2:    prod_shifted = {r_prod, 64'd0};
            default: prod_shifted = '0;
        endcase
    end

    assign mul_acc  = (r_step == 3'd0) ? 128'd0 : (r_acc + prod_shifted);
    assign low      = mul_acc[63:0];
    assign mix0_val = (r_x + sm64ke_pkg::GOLD) ^ ((r_x + sm64ke_pkg::GOLD) >> sm64ke_pkg::SHIFT_A);
    assign m1_val   = low ^ (low >> sm64ke_pkg::SHIFT_B);
    assign m2_val   = low ^ (low >> sm64ke_pkg::SHIFT_C);

    // Floor of u * range / 2^64 added to the low bound; for a reversed range
    // the product is subtracted and rounded away from the low bound.
    assign unif_word = r_cmd.neg
        ? (r_cmd.low - (r_acc[127:64] + {63'd0, (r_acc[63:0] != 64'd0)}))
        : (r_cmd.low + r_acc[127:64]);
    assign emit_word = r_cmd.uniform ? unif_word : r_x;
    assign emit_last = (r_idx == r_cmd.last_idx);
    assign out_free  = !r_out_valid || i_pop;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_x        = r_x;
        n_base     = r_base;
        n_idx      = r_idx;
        n_pre_done = r_pre_done;
        n_step     = (in_mult && !mul_done) ? (r_step + 3'd1) : 3'd0;
        n_acc      = in_mult ? mul_acc : r_acc;
        o_q_pop    = 1'b0;
        emit       = 1'b0;
        unique case (r_state)
            sm64ke_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop    = 1'b1;
                    n_cmd      = i_q_head;
                    n_x        = i_q_head.operand;
                    n_base     = i_q_head.operand;
                    n_idx      = 6'd0;
                    n_pre_done = 1'b0;
                    n_state    = i_q_head.premul ? sm64ke_pkg::B_PRE : sm64ke_pkg::B_MIX0;
                end
            end
            sm64ke_pkg::B_PRE: begin
                if (mul_done) begin
                    n_x     = r_cmd.xor_word ^ low;
                    n_state = sm64ke_pkg::B_MIX0;
                end
            end
            sm64ke_pkg::B_MIX0: begin
                n_x     = mix0_val;
                n_state = sm64ke_pkg::B_M1;
            end
            sm64ke_pkg::B_M1: begin
                if (mul_done) begin
                    n_x     = m1_val;
                    n_state = sm64ke_pkg::B_M2;
                end
            end
            sm64ke_pkg::B_M2: begin
                if (mul_done) begin
                    n_x = m2_val;
                    if (r_cmd.uniform) begin
                        n_state = sm64ke_pkg::B_SCALE;
                    end else if (r_cmd.pre_mix && !r_pre_done) begin
                        n_pre_done = 1'b1;
                        n_base     = m2_val;
                        n_state    = sm64ke_pkg::B_MIX0;
                    end else begin
                        n_state = sm64ke_pkg::B_EMIT;
                    end
                end
            end
            sm64ke_pkg::B_SCALE: begin
                if (mul_done) begin
                    n_state = sm64ke_pkg::B_EMIT;
                end
            end
            sm64ke_pkg::B_EMIT: begin
                if (out_free) begin
                    emit  = 1'b1;
                    n_idx = r_idx + 6'd1;
                    n_x   = r_cmd.uniform ? r_x : (r_base ^ sm64ke_pkg::GOLD);
                    n_state = emit_last ? sm64ke_pkg::B_IDLE : sm64ke_pkg::B_MIX0;
                end
            end
            default: begin
                n_state = sm64ke_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sm64ke_pkg::B_IDLE;
            r_step      <= '0;
            r_pre_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_pre_done  <= n_pre_done;
            r_out_valid <= emit ? 1'b1 : (i_pop ? 1'b0 : r_out_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_x    <= n_x;
        r_base <= n_base;
        r_idx  <= n_idx;
        r_prod <= n_prod;
        r_psh  <= n_psh;
        r_acc  <= n_acc;
        if (emit) begin
            r_out_word <= emit_word;
            r_out_idx  <= r_idx;
            r_out_last <= emit_last;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_word         = r_out_word;
    assign o_result_index = r_out_idx;
    assign o_last         = r_out_last;

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sm64ke_pkg::B_IDLE) |-> (r_idx <= r_cmd.last_idx))
        else $error("result index ran past the end of the run");

    a_scale_uniform: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sm64ke_pkg::B_SCALE) |-> r_cmd.uniform)
        else $error("scaling entered for a key command");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_mult |-> (r_step <= step_last))
        else $error("multiplier step count overran");

    a_pair_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_cmd.pre_mix) |-> r_pre_done)
        else $error("key pair result emitted before its base key was formed");

endmodule

// ----- rtl/splitmix64_key_and_uniform_engine.sv -----
// Top level of the splitmix64 key and uniform engine: front end, command
// queue and back end. Depends on sm64ke_pkg, sm64ke_front, sm64ke_cmdq and
// sm64ke_back.
//
// Requests enter through a queue-like port: a request is taken at a rising
// edge where push is high and full is low. The func field selects key,
// key pair, split, fold_in or uniform; unused codes and uniform requests
// with a zero count are taken and produce nothing. Results leave the same
// way: while empty is low the oldest result sits on o_word, o_result_index
// and o_last, and pop takes it. o_last marks the final result of a request.
// All products run on one shared 32x32 multiplier, built from three partial
// products for a 64-bit product modulo 2^64 and from four for the full
// product used in scaling. Key, key pair and fold_in requests first
// multiply by GOLD and xor; a key pair runs one hidden mix pass before its
// two results, and each uniform value is a mix pass then a scaling step.
// A two-entry command queue lets new requests be taken while the back end
// is busy, and one result register lets the back end finish the next result
// while the current one waits. A stalled receiver holds the result register,
// then the back end, then the queue, and full rises. Reset clears the key
// counter, the queue and the result register.
module splitmix64_key_and_uniform_engine #(
    parameter int MAX_VALUES = sm64ke_pkg::MAX_VALUES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          i_func,
    input  logic [63:0]         i_entropy,
    input  logic [63:0]         i_key_in,
    input  logic [63:0]         i_fold_value,
    input  logic [6:0]          i_value_count,
    input  logic signed [63:0]  i_low_bound,
    input  logic signed [63:0]  i_high_bound,
    output logic                empty,
    input  logic                pop,
    output logic [63:0]         o_word,
    output logic [5:0]          o_result_index,
    output logic                o_last
);

    sm64ke_pkg::t_cmd q_wr_cmd;
    sm64ke_pkg::t_cmd q_head;
    logic             q_wr;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;

    // The front end classifies each request and writes one command per
    // request that produces results.
    sm64ke_front #(
        .MAX_VALUES (MAX_VALUES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_func        (i_func),
        .i_entropy     (i_entropy),
        .i_key_in      (i_key_in),
        .i_fold_value  (i_fold_value),
        .i_value_count (i_value_count),
        .i_low_bound   (i_low_bound),
        .i_high_bound  (i_high_bound),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr),
        .o_cmd         (q_wr_cmd)
    );

    sm64ke_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (q_wr_cmd),
        .i_rd    (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The back end pulls one command at a time and produces its results.
    sm64ke_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_head       (q_head),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_word         (o_word),
        .o_result_index (o_result_index),
        .o_last         (o_last)
    );

    assign full = q_full;

endmodule
